// File: design/conv3_pkg.sv
// Shared constants and types for the 3x3 RGB convolution block.
// No dependencies; used by the lane, line buffer and top level.
package conv3_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int PIX_W         = 8;
  localparam int PLANES        = 3;
  localparam int TAPS          = 9;
  localparam int WCALC         = 14;
  localparam int HCALC         = 13;
  localparam int ROW_W         = 12;
  localparam int DIV_W         = 12;
  localparam int CFG_DATA_W    = 24;
  localparam int CFG_IDX_W     = 3;
  localparam logic [HCALC-1:0] HEIGHT_LIMIT = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIV    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd5;

  // status of one plane lane toward the merge stage
  typedef struct packed {
    logic             done;
    logic [PIX_W-1:0] value;
  } lane_out_t;

endpackage

// File: design/conv3_line_buf.sv
// Two-row line buffer: upper and lower rows packed side by side in one memory.
// Uses conv3_pkg for the default depth.
module conv3_line_buf #(
  parameter int MAX_WIDTH = conv3_pkg::MAX_WIDTH_DEF,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [2*24-1:0]       rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [2*24-1:0]       wr_data
);

  logic [2*24-1:0] mem [MAX_WIDTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/conv3_lane.sv
// One colour-plane lane: row-by-row multiply-accumulate, then saturating
// restoring division one quotient bit per cycle. Uses conv3_pkg.
module conv3_lane (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [conv3_pkg::PIX_W-1:0]     pix  [conv3_pkg::TAPS],
  input  logic signed [7:0]               coef [conv3_pkg::TAPS],
  input  logic [conv3_pkg::DIV_W-1:0]     div,
  output conv3_pkg::lane_out_t            status
);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_MAC  = 2'd1;
  localparam logic [1:0] L_DIV  = 2'd2;
  localparam logic [1:0] L_DONE = 2'd3;

  logic [1:0]          state;
  logic [2:0]          cnt;
  logic signed [19:0]  acc;
  logic [18:0]         rem;
  logic [18:0]         dsh;
  logic [7:0]          quo;
  logic signed [18:0]  row_sum;
  logic [3:0]          base;

  // sum of the three products of the current kernel row
  always_comb begin
    base = {2'b0, cnt[1:0]} * 4'd3;
    row_sum = ($signed({11'b0, pix[base]})        * 19'(coef[base]))
            + ($signed({11'b0, pix[base + 4'd1]}) * 19'(coef[base + 4'd1]))
            + ($signed({11'b0, pix[base + 4'd2]}) * 19'(coef[base + 4'd2]));
  end

  // sequence accumulate, saturate check and divide
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        L_IDLE, L_DONE: begin
          if (start) begin
            state <= L_MAC;
            cnt   <= '0;
            acc   <= '0;
          end
        end
        L_MAC: begin
          if (cnt == 3'd3) begin
            // truncation toward zero of a non-positive sum clamps to zero
            if (acc <= 20'sd0) begin
              quo   <= '0;
              state <= L_DONE;
            end else if ({1'b0, acc[18:0]} >= {div, 8'b0}) begin
              quo   <= 8'hFF;
              state <= L_DONE;
            end else begin
              rem   <= acc[18:0];
              dsh   <= {div, 7'b0};
              quo   <= '0;
              cnt   <= '0;
              state <= L_DIV;
            end
          end else begin
            acc <= acc + 20'(row_sum);
            cnt <= cnt + 3'd1;
          end
        end
        L_DIV: begin
          if (rem >= dsh) begin
            rem <= rem - dsh;
            quo <= {quo[6:0], 1'b1};
          end else begin
            quo <= {quo[6:0], 1'b0};
          end
          dsh <= dsh >> 1;
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            state <= L_DONE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign status.done  = (state == L_DONE);
  assign status.value = quo;

endmodule

// File: design/conv3x3_rgb_divide_clamp.sv
// 3x3 RGB convolution with divide and clamp. Pixels enter in raster order,
// one beat at a time; each is accepted with a line buffer read, then the line
// buffer is written and the window shifted. An interior pixel then passes the
// plane lanes (start, accumulation of the three kernel rows, saturation check,
// hand-off) plus 8 divide steps unless the sum clamps; a stalled output
// register holds it back. A finished result waits in the output register while
// the next pixel enters.
// Border pixels give no result; frame_last flags the last interior result.
module conv3x3_rgb_divide_clamp #(
  parameter int MAX_WIDTH = conv3_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [conv3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [conv3_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          red_in,
  input  logic [7:0]                          green_in,
  input  logic [7:0]                          blue_in,
  input  logic                                frame_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          red_out,
  output logic [7:0]                          green_out,
  output logic [7:0]                          blue_out,
  output logic                                frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WC = conv3_pkg::WCALC;
  localparam int HC = conv3_pkg::HCALC;
  localparam int RW = conv3_pkg::ROW_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RMW  = 2'd1;
  localparam logic [1:0] S_CALC = 2'd2;

  logic [1:0]     state;
  logic [23:0]    coef_row [3];
  logic [11:0]    divisor;
  logic [10:0]    image_width;
  logic [12:0]    image_height;
  logic [CW-1:0]  column_count;
  logic [RW-1:0]  row_count;
  logic [CW-1:0]  col_l;
  logic [RW-1:0]  row_l;
  logic [23:0]    pix_l;
  logic [23:0]    window_regs [9];
  logic           last_l;
  logic [47:0]    rd_data;
  logic [CW-1:0]  col_use;
  logic [RW-1:0]  row_use;
  logic [WC-1:0]  w_eff;
  logic [HC-1:0]  h_eff;
  logic [WC-1:0]  colx;
  logic [HC-1:0]  rowx;
  logic           emit;
  logic           is_last;
  logic [11:0]    div_eff;
  logic           lane_start;
  logic           lanes_done;
  logic           accept;
  conv3_pkg::lane_out_t   lane_st [conv3_pkg::PLANES];
  logic signed [7:0]      coef [conv3_pkg::TAPS];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_row[0]  <= 24'd0;
      coef_row[1]  <= 24'd256;
      coef_row[2]  <= 24'd0;
      divisor      <= 12'd1;
      image_width  <= 11'd1024;
      image_height <= 13'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        conv3_pkg::REG_COEF0:  coef_row[0]  <= cfg_data;
        conv3_pkg::REG_COEF1:  coef_row[1]  <= cfg_data;
        conv3_pkg::REG_COEF2:  coef_row[2]  <= cfg_data;
        conv3_pkg::REG_DIV:    divisor      <= cfg_data[11:0];
        conv3_pkg::REG_WIDTH:  image_width  <= cfg_data[10:0];
        conv3_pkg::REG_HEIGHT: image_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // effective frame size and divisor
  always_comb begin
    w_eff = {3'b0, image_width};
    if (w_eff == '0) w_eff = WC'(1);
    if (w_eff > WC'(MAX_WIDTH)) w_eff = WC'(MAX_WIDTH);
    h_eff = image_height;
    if (h_eff == '0) h_eff = HC'(1);
    if (h_eff > conv3_pkg::HEIGHT_LIMIT) h_eff = conv3_pkg::HEIGHT_LIMIT;
    div_eff = (divisor == '0) ? 12'd1 : divisor;
    colx    = WC'(col_l);
    rowx    = HC'(row_l);
    emit    = (row_l >= RW'(2)) && (rowx < h_eff) && (col_l >= CW'(2)) && (colx < w_eff);
    is_last = (rowx == h_eff - HC'(1)) && (colx == w_eff - WC'(1));
  end

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign col_use  = frame_start ? '0 : column_count;
  assign row_use  = frame_start ? '0 : row_count;

  conv3_line_buf #(.MAX_WIDTH(MAX_WIDTH), .AW(CW)) u_line (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_use),
    .rd_data (rd_data),
    .wr_en   (state == S_RMW),
    .wr_addr (col_l),
    .wr_data ({rd_data[23:0], pix_l})
  );

  // sequence each pixel: read, update window and counters, then filter interior pixels
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      column_count <= '0;
      row_count    <= '0;
      lane_start   <= 1'b0;
      for (int k = 0; k < 9; k++) window_regs[k] <= '0;
    end else begin
      lane_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            col_l <= col_use;
            row_l <= row_use;
            pix_l <= {blue_in, green_in, red_in};
            state <= S_RMW;
          end
        end
        S_RMW: begin
          for (int r = 0; r < 3; r++) begin
            window_regs[3*r]   <= window_regs[3*r+1];
            window_regs[3*r+1] <= window_regs[3*r+2];
          end
          window_regs[2] <= rd_data[47:24];
          window_regs[5] <= rd_data[23:0];
          window_regs[8] <= pix_l;
          if (WC'(col_l) + WC'(1) >= w_eff) begin
            column_count <= '0;
            row_count    <= (HC'(row_l) + HC'(1) >= h_eff) ? '0 : row_l + RW'(1);
          end else begin
            column_count <= col_l + CW'(1);
            row_count    <= row_l;
          end
          last_l <= is_last;
          if (emit) begin
            lane_start <= 1'b1;
            state      <= S_CALC;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CALC: begin
          if (!lane_start && lanes_done && (!out_valid || out_ready)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // unpack kernel taps
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        coef[3*r+c] = $signed(coef_row[r][8*c +: 8]);
      end
    end
  end

  for (genvar p = 0; p < conv3_pkg::PLANES; p++) begin : g_lane
    logic [7:0] plane_pix [conv3_pkg::TAPS];
    always_comb begin
      for (int k = 0; k < conv3_pkg::TAPS; k++) plane_pix[k] = window_regs[k][8*p +: 8];
    end
    conv3_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .start  (lane_start),
      .pix    (plane_pix),
      .coef   (coef),
      .div    (div_eff),
      .status (lane_st[p])
    );
  end

  assign lanes_done = lane_st[0].done && lane_st[1].done && lane_st[2].done;

  // merge lane results into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_CALC && !lane_start && lanes_done && (!out_valid || out_ready)) begin
      out_valid  <= 1'b1;
      red_out    <= lane_st[0].value;
      green_out  <= lane_st[1].value;
      blue_out   <= lane_st[2].value;
      frame_last <= last_l;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_rmw: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_RMW) else $error("accepted beat did not enter line update");
  a_rmw_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_RMW |=> (state == S_IDLE || state == S_CALC))
    else $error("line update did not finish in one cycle");
  a_load_from_calc: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_CALC) else $error("result loaded outside filter");
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    CW'(MAX_WIDTH - 1) >= column_count) else $error("column count beyond line buffer");
`endif

endmodule

// File: test/conv3_checker.sv
// Checker for the 3x3 RGB convolution block: tracks the register writes, predicts each
// result from the accepted pixel beats, and compares the output beats in order.
// Depends on conv3_pkg for the register indexes and port widths.
module conv3_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [conv3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [conv3_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [7:0]                       red_in,
  input  logic [7:0]                       green_in,
  input  logic [7:0]                       blue_in,
  input  logic                             frame_start,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [7:0]                       red_out,
  input  logic [7:0]                       green_out,
  input  logic [7:0]                       blue_out,
  input  logic                             frame_last,
  output int                               errors,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_DEPTH = conv3_pkg::MAX_WIDTH_DEF;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } filtered_pix_t;

  filtered_pix_t filtered_q[$];

  // shadow of the register file
  logic [23:0] k_row[3];
  logic [11:0] div_reg;
  logic [10:0] width_reg;
  logic [12:0] height_reg;

  // shadow of the pixel pipeline
  logic [23:0] row_minus2[LINE_DEPTH];
  logic [23:0] row_minus1[LINE_DEPTH];
  logic [23:0] win[9];
  int unsigned col_cnt, row_cnt;

  assign pending = filtered_q.size();

  function automatic logic [7:0] filter_plane(int shift, int dv);
    int acc;
    int px;
    int cf;
    acc = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        px = (win[3*r+c] >> shift) & 8'hFF;
        cf = $signed(k_row[r][8*c +: 8]);
        acc += px * cf;
      end
    end
    acc = acc / dv;
    if (acc < 0) acc = 0;
    if (acc > 255) acc = 255;
    return acc[7:0];
  endfunction

  // Advance the shadow pipeline by one pixel; queue a result for interior centres.
  task automatic filter_pixel(logic [7:0] rd, logic [7:0] gr, logic [7:0] bl, logic fs);
    int unsigned w, h, dv, cc, rr;
    logic [23:0] pix, up, lo;
    filtered_pix_t res;
    w  = width_reg;
    h  = height_reg;
    dv = (div_reg == 0) ? 1 : div_reg;
    if (w < 1) w = 1;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    if (h < 1) h = 1;
    if (h > 4096) h = 4096;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    cc  = col_cnt;
    rr  = row_cnt;
    pix = {bl, gr, rd};
    up  = '0;
    lo  = '0;
    if (cc < LINE_DEPTH) begin
      up = row_minus2[cc];
      lo = row_minus1[cc];
      row_minus2[cc] = lo;
      row_minus1[cc] = pix;
    end
    for (int r = 0; r < 3; r++) begin
      win[3*r]   = win[3*r+1];
      win[3*r+1] = win[3*r+2];
    end
    win[2] = up;
    win[5] = lo;
    win[8] = pix;
    if (rr >= 2 && rr < h && cc >= 2 && cc < w) begin
      res.red   = filter_plane(0, dv);
      res.green = filter_plane(8, dv);
      res.blue  = filter_plane(16, dv);
      res.last  = (rr == h - 1 && cc == w - 1);
      filtered_q.push_back(res);
    end
    if (cc + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (rr + 1 >= h) ? 0 : rr + 1;
    end else begin
      col_cnt = cc + 1;
    end
  endtask

  initial begin
    errors = 0;
  end

  always @(posedge clk) begin
    filtered_pix_t exp_pix;
    if (rst) begin
      k_row[0]   = 24'h0;
      k_row[1]   = 24'h000100;
      k_row[2]   = 24'h0;
      div_reg    = 12'd1;
      width_reg  = 11'd1024;
      height_reg = 13'd1024;
      for (int i = 0; i < 9; i++) win[i] = '0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
        row_minus2[i] = '0;
        row_minus1[i] = '0;
      end
      col_cnt = 0;
      row_cnt = 0;
      filtered_q.delete();
    end else begin
      // compare the output beat first: it never stems from this edge's input
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected output beat: red %0d green %0d blue %0d last %0b",
                 red_out, green_out, blue_out, frame_last);
          errors++;
        end else begin
          exp_pix = filtered_q.pop_front();
          if (red_out !== exp_pix.red) begin
            $error("red_out: expected %0d, got %0d", exp_pix.red, red_out);
            errors++;
          end
          if (green_out !== exp_pix.green) begin
            $error("green_out: expected %0d, got %0d", exp_pix.green, green_out);
            errors++;
          end
          if (blue_out !== exp_pix.blue) begin
            $error("blue_out: expected %0d, got %0d", exp_pix.blue, blue_out);
            errors++;
          end
          if (frame_last !== exp_pix.last) begin
            $error("frame_last: expected %0b, got %0b", exp_pix.last, frame_last);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        filter_pixel(red_in, green_in, blue_in, frame_start);
      if (cfg_we) begin
        case (cfg_index)
          conv3_pkg::REG_COEF0:  k_row[0]   = cfg_data;
          conv3_pkg::REG_COEF1:  k_row[1]   = cfg_data;
          conv3_pkg::REG_COEF2:  k_row[2]   = cfg_data;
          conv3_pkg::REG_DIV:    div_reg    = cfg_data[11:0];
          conv3_pkg::REG_WIDTH:  width_reg  = cfg_data[10:0];
          conv3_pkg::REG_HEIGHT: height_reg = cfg_data[12:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: test/testbench.sv
// Top of the convolution regression: clock, reset, register writes and pixel stimulus.
// Depends on conv3_pkg, the block under test and conv3_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 660;

  logic        clk, rst;
  logic        cfg_we;
  logic [conv3_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [conv3_pkg::CFG_DATA_W-1:0] cfg_data;
  logic        in_valid, in_ready;
  logic [7:0]  red_in, green_in, blue_in;
  logic        frame_start;
  logic        out_valid, out_ready;
  logic [7:0]  red_out, green_out, blue_out;
  logic        frame_last;
  int          errors, pending;
  int          tx_idle_pct, rx_idle_pct;
  int          cycle_cnt;
  int          pix_sent;

  conv3x3_rgb_divide_clamp i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .red_in, .green_in, .blue_in, .frame_start,
    .out_valid, .out_ready, .red_out, .green_out, .blue_out, .frame_last
  );

  conv3_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("conv3x3_rgb_divide_clamp regression: fail");
      $finish;
    end
  end

  // Drive one pixel beat and hold it until accepted.
  task automatic send_pixel(logic [7:0] rd, logic [7:0] gr, logic [7:0] bl, logic fs);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    red_in      <= rd;
    green_in    <= gr;
    blue_in     <= bl;
    frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    pix_sent++;
  endtask

  // Drain outstanding results, then let the block go quiet.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [conv3_pkg::CFG_IDX_W-1:0] idx,
                           logic [conv3_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_all(logic [23:0] k0, logic [23:0] k1, logic [23:0] k2,
                           int dv, int w, int h);
    write_reg(conv3_pkg::REG_COEF0, k0);
    write_reg(conv3_pkg::REG_COEF1, k1);
    write_reg(conv3_pkg::REG_COEF2, k2);
    write_reg(conv3_pkg::REG_DIV, 24'(dv));
    write_reg(conv3_pkg::REG_WIDTH, 24'(w));
    write_reg(conv3_pkg::REG_HEIGHT, 24'(h));
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Send a frame of random pixels; noisy frames get stray frame_start beats.
  task automatic send_frame(int w, int h, bit mark_start, bit noisy);
    for (int i = 0; i < w * h; i++) begin
      send_pixel(rand_byte(), rand_byte(), rand_byte(),
                 (i == 0 && mark_start) || (noisy && $urandom_range(99) < 3));
    end
  endtask

  task automatic pick_config(output int w, output int h);
    int dv;
    case ($urandom_range(5))
      0: dv = 1;
      1: dv = 4095;
      2: dv = $urandom_range(4095, 1);
      default: dv = $urandom_range(64, 1);
    endcase
    w = $urandom_range(10, 3);
    h = $urandom_range(7, 3);
    write_all(24'($urandom_range(24'hFFFFFF)), 24'($urandom_range(24'hFFFFFF)),
              24'($urandom_range(24'hFFFFFF)), dv, w, h);
  endtask

  initial begin
    int w, h;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    red_in      = '0;
    green_in    = '0;
    blue_in     = '0;
    frame_start = 1'b0;
    tx_idle_pct = 13;
    rx_idle_pct = 54;
    cycle_cnt   = 0;
    pix_sent    = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity kernel from reset, minimum frame, extreme pixels
    write_reg(conv3_pkg::REG_WIDTH, 24'd3);
    write_reg(conv3_pkg::REG_HEIGHT, 24'd3);
    for (int i = 0; i < 9; i++)
      send_pixel((i % 2) ? 8'd255 : 8'd0, (i % 3) ? 8'd0 : 8'd255, 8'(255 - i), i == 0);
    wait_idle();

    // largest positive kernel saturates high, then most negative clamps at zero
    write_all(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 1, 4, 3);
    for (int i = 0; i < 12; i++) send_pixel(8'd255, 8'd255, 8'd255, i == 0);
    wait_idle();
    write_all(24'h808080, 24'h808080, 24'h808080, 4095, 3, 3);
    for (int i = 0; i < 9; i++) send_pixel(8'd255, 8'd1, 8'd128, i == 0);
    wait_idle();

    // widest row wraps the column count at full width, and the tallest height
    // is cut short by a new frame
    write_all(24'h01FF02, 24'h03F801, 24'hFE0201, 3, 1024, 1);
    send_frame(1024, 1, 1'b1, 1'b0);
    wait_idle();
    write_all(24'h010101, 24'h010101, 24'h010101, 9, 4, 4096);
    send_frame(4, 5, 1'b1, 1'b0);
    wait_idle();

    // random frames in three idling modes
    pix_sent = 0;
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 54 : 0;
      rx_idle_pct = (mode == 0) ? 54 : (mode == 1) ? 13 : 0;
      while (pix_sent < RANDOM_ITEMS * (mode + 1) / 3) begin
        pick_config(w, h);
        send_frame(w, h, 1'b1, $urandom_range(9) == 0);
        // back-to-back frame relying on counter wrap
        if ($urandom_range(2) == 0) send_frame(w, h, 1'b0, 1'b0);
        // hold the sender mid-frame until every result is out
        if (mode == 1 && $urandom_range(7) == 0) begin
          send_frame(w, 1, 1'b1, 1'b0);
          in_valid <= 1'b0;
          while (pending != 0) @(posedge clk);
          send_frame(w, h - 1, 1'b0, 1'b0);
        end
        wait_idle();
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("conv3x3_rgb_divide_clamp regression: pass");
    end else begin
      $display("conv3x3_rgb_divide_clamp regression: fail");
    end
    $finish;
  end

endmodule
